// ===== sv/evs_pkg.sv =====
// ----------------------------------------------------------------------------
// evs_pkg: shared constants for the signature verify block
// Field widths, register map and reset values of the configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

package evs_pkg;

   // default operand width of the modulus
   localparam int MOD_BITS_DEF = 16;

   // widths of item fields and configuration registers
   localparam int FIELD_W    = 16;
   localparam int REG_W      = 16;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;
   localparam int REG_IDX_W  = 2;

   // register indexes (byte address is 4 * index)
   localparam logic [REG_IDX_W-1:0] REG_MODULUS    = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_GENERATOR  = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_PUBLIC_KEY = 2'd2;

   // reset values
   localparam logic [REG_W-1:0] MODULUS_RST    = 16'd2;
   localparam logic [REG_W-1:0] GENERATOR_RST  = 16'd1;
   localparam logic [REG_W-1:0] PUBLIC_KEY_RST = 16'd1;

endpackage

`default_nettype wire

// ===== sv/evs_modmul.sv =====
// ----------------------------------------------------------------------------
// evs_modmul: iterative modular multiplier
// Forms a*b in one registered step, then reduces mod p by restoring
// division, one product bit per cycle. done pulses with the residue ready.
// ----------------------------------------------------------------------------
`default_nettype none

module evs_modmul #(
   parameter int MOD_BITS = evs_pkg::MOD_BITS_DEF,
   parameter int OPW      = evs_pkg::FIELD_W
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [OPW-1:0]      op_a,
   input  wire logic [OPW-1:0]      op_b,
   input  wire logic [MOD_BITS-1:0] modulus,
   output logic                     done,
   output logic [MOD_BITS-1:0]      result
);

   localparam int PW = 2 * OPW;
   localparam int CW = $clog2(PW);

   localparam logic [1:0] U_IDLE = 2'd0;
   localparam logic [1:0] U_MUL  = 2'd1;
   localparam logic [1:0] U_RED  = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic                done_ff, done_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [OPW-1:0]      a_ff, a_in;
   logic [OPW-1:0]      b_ff, b_in;
   logic [MOD_BITS-1:0] p_ff, p_in;
   logic [PW-1:0]       prod_ff, prod_in;
   logic [MOD_BITS-1:0] rem_ff, rem_in;
   logic [MOD_BITS:0]   trial;

   // one restoring step: bring down the next product bit, subtract if it fits
   assign trial = {rem_ff, prod_ff[PW-1]};

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      p_in     = p_ff;
      prod_in  = prod_ff;
      rem_in   = rem_ff;
      case (state_ff)
         U_IDLE: begin
            if (start) begin
               a_in     = op_a;
               b_in     = op_b;
               p_in     = modulus;
               state_in = U_MUL;
            end
         end
         U_MUL: begin
            prod_in  = a_ff * b_ff;
            rem_in   = '0;
            cnt_in   = CW'(PW - 1);
            state_in = U_RED;
         end
         U_RED: begin
            if (trial >= {1'b0, p_ff}) begin
               rem_in = MOD_BITS'(trial - {1'b0, p_ff});
            end else begin
               rem_in = trial[MOD_BITS-1:0];
            end
            prod_in = {prod_ff[PW-2:0], 1'b0};
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               done_in  = 1'b1;
               state_in = U_IDLE;
            end
         end
         default: begin
            state_in = U_IDLE;
         end
      endcase
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      p_ff    <= p_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
   end

   assign done   = done_ff;
   assign result = rem_ff;

endmodule

`default_nettype wire

// ===== sv/elgamal_signature_verify.sv =====
// Operation: a modulus below two is answered without any modular product; otherwise
//   the modular products are three base reductions, one per set exponent bit, one
//   square per bit below the top set bit and one final product, all at OPW =
//   max(MOD_BITS, 16) bits; the shared unit does one bit a cycle.
// Throughput: one item at a time; busy drops with the result strobe, which the
//   receiver cannot stall. Reset: synchronous; modulus 2, generator 1, key 1.
// ----------------------------------------------------------------------------
// elgamal_signature_verify: signature check top level
// Computes y^s1 * s1^s2 and g^m mod p by square-and-multiply on one shared
// modular multiplier and strobes whether they match.
// ----------------------------------------------------------------------------
`default_nettype none

module elgamal_signature_verify #(
   parameter int MOD_BITS = evs_pkg::MOD_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // configuration port
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [evs_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [evs_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic      [evs_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                                 pready,
   // item input
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [evs_pkg::FIELD_W-1:0]     req_sig_first,
   input  wire logic [evs_pkg::FIELD_W-1:0]     req_sig_second,
   input  wire logic [evs_pkg::FIELD_W-1:0]     req_message,
   // result
   output logic                                 rsp_valid,
   output logic                                 rsp_verified
);

   localparam int FW  = evs_pkg::FIELD_W;
   localparam int OPW = (MOD_BITS > FW) ? MOD_BITS : FW;

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_START = 3'd1;
   localparam logic [2:0] S_PREP  = 3'd2;
   localparam logic [2:0] S_BASE  = 3'd3;
   localparam logic [2:0] S_LOOP  = 3'd4;
   localparam logic [2:0] S_MUL   = 3'd5;
   localparam logic [2:0] S_SQR   = 3'd6;
   localparam logic [2:0] S_COMB  = 3'd7;

   // which power is being formed
   localparam logic [1:0] PH_KEY = 2'd0;
   localparam logic [1:0] PH_SIG = 2'd1;
   localparam logic [1:0] PH_GEN = 2'd2;

   logic [evs_pkg::REG_W-1:0] modulus_ff, generator_ff, public_key_ff;
   logic [2:0]                state_ff, state_in;
   logic [1:0]                phase_ff, phase_in;
   logic [FW-1:0]             exp_ff, exp_in;
   logic [MOD_BITS-1:0]       acc_ff, acc_in;
   logic [MOD_BITS-1:0]       base_ff, base_in;
   logic [MOD_BITS-1:0]       lhs_ff, lhs_in;
   logic [FW-1:0]             s1_ff, s2_ff, msg_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_verified_ff, rsp_verified_in;

   logic                      cfg_write;
   logic [evs_pkg::REG_IDX_W-1:0] cfg_idx;
   logic [MOD_BITS-1:0]       p_op;
   logic [OPW-1:0]            base_raw;
   logic [FW-1:0]             exp_raw;
   logic                      mm_start;
   logic [OPW-1:0]            mm_a, mm_b;
   logic                      mm_done;
   logic [MOD_BITS-1:0]       mm_result;
   logic                      accept;

   // configuration registers
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;
   assign cfg_idx   = paddr[evs_pkg::CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff    <= evs_pkg::MODULUS_RST;
         generator_ff  <= evs_pkg::GENERATOR_RST;
         public_key_ff <= evs_pkg::PUBLIC_KEY_RST;
      end else if (cfg_write) begin
         case (cfg_idx)
            evs_pkg::REG_MODULUS:    modulus_ff    <= pwdata[evs_pkg::REG_W-1:0];
            evs_pkg::REG_GENERATOR:  generator_ff  <= pwdata[evs_pkg::REG_W-1:0];
            evs_pkg::REG_PUBLIC_KEY: public_key_ff <= pwdata[evs_pkg::REG_W-1:0];
            default: ;
         endcase
      end
   end

   // register read-back
   always_comb begin
      case (cfg_idx)
         evs_pkg::REG_MODULUS:    prdata = evs_pkg::CSR_DATA_W'(modulus_ff);
         evs_pkg::REG_GENERATOR:  prdata = evs_pkg::CSR_DATA_W'(generator_ff);
         evs_pkg::REG_PUBLIC_KEY: prdata = evs_pkg::CSR_DATA_W'(public_key_ff);
         default:                 prdata = '0;
      endcase
   end

   // operands taken at the modulus width
   assign p_op   = MOD_BITS'(modulus_ff);
   assign accept = start && !busy;

   // base and exponent of the current power
   always_comb begin
      case (phase_ff)
         PH_KEY: begin
            base_raw = OPW'(MOD_BITS'(public_key_ff));
            exp_raw  = s1_ff;
         end
         PH_SIG: begin
            base_raw = OPW'(s1_ff);
            exp_raw  = s2_ff;
         end
         default: begin
            base_raw = OPW'(MOD_BITS'(generator_ff));
            exp_raw  = msg_ff;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in        = state_ff;
      phase_in        = phase_ff;
      exp_in          = exp_ff;
      acc_in          = acc_ff;
      base_in         = base_ff;
      lhs_in          = lhs_ff;
      rsp_valid_in    = 1'b0;
      rsp_verified_in = rsp_verified_ff;
      mm_start        = 1'b0;
      mm_a            = OPW'(acc_ff);
      mm_b            = OPW'(base_ff);
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_START;
            end
         end
         S_START: begin
            // a modulus below two never verifies
            if (p_op < MOD_BITS'(2)) begin
               rsp_valid_in    = 1'b1;
               rsp_verified_in = 1'b0;
               state_in        = S_IDLE;
            end else begin
               phase_in = PH_KEY;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            // reduce the base, acc starts at one
            mm_start = 1'b1;
            mm_a     = base_raw;
            mm_b     = OPW'(1);
            exp_in   = exp_raw;
            acc_in   = MOD_BITS'(1);
            state_in = S_BASE;
         end
         S_BASE: begin
            if (mm_done) begin
               base_in  = mm_result;
               state_in = S_LOOP;
            end
         end
         S_LOOP: begin
            if (exp_ff == '0) begin
               case (phase_ff)
                  PH_KEY: begin
                     lhs_in   = acc_ff;
                     phase_in = PH_SIG;
                     state_in = S_PREP;
                  end
                  PH_SIG: begin
                     mm_start = 1'b1;
                     mm_a     = OPW'(lhs_ff);
                     mm_b     = OPW'(acc_ff);
                     state_in = S_COMB;
                  end
                  default: begin
                     rsp_valid_in    = 1'b1;
                     rsp_verified_in = (lhs_ff == acc_ff);
                     state_in        = S_IDLE;
                  end
               endcase
            end else if (exp_ff[0]) begin
               mm_start = 1'b1;
               state_in = S_MUL;
            end else begin
               mm_start = 1'b1;
               mm_a     = OPW'(base_ff);
               state_in = S_SQR;
            end
         end
         S_MUL: begin
            if (mm_done) begin
               acc_in = mm_result;
               // skip the square once no exponent bits remain
               if (exp_ff[FW-1:1] == '0) begin
                  exp_in   = '0;
                  state_in = S_LOOP;
               end else begin
                  mm_start = 1'b1;
                  mm_a     = OPW'(base_ff);
                  state_in = S_SQR;
               end
            end
         end
         S_SQR: begin
            if (mm_done) begin
               base_in  = mm_result;
               exp_in   = {1'b0, exp_ff[FW-1:1]};
               state_in = S_LOOP;
            end
         end
         S_COMB: begin
            if (mm_done) begin
               lhs_in   = mm_result;
               phase_in = PH_GEN;
               state_in = S_PREP;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      phase_ff        <= phase_in;
      exp_ff          <= exp_in;
      acc_ff          <= acc_in;
      base_ff         <= base_in;
      lhs_ff          <= lhs_in;
      rsp_verified_ff <= rsp_verified_in;
      if (accept) begin
         s1_ff  <= req_sig_first;
         s2_ff  <= req_sig_second;
         msg_ff <= req_message;
      end
   end

   // shared multiply and reduce unit
   evs_modmul #(
      .MOD_BITS (MOD_BITS),
      .OPW      (OPW)
   ) u_modmul (
      .clock   (clock),
      .reset   (reset),
      .start   (mm_start),
      .op_a    (mm_a),
      .op_b    (mm_b),
      .modulus (p_op),
      .done    (mm_done),
      .result  (mm_result)
   );

   assign busy         = (state_ff != S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_verified = rsp_verified_ff;

endmodule

`default_nettype wire

// ===== sv/evs_checker.sv =====
// ----------------------------------------------------------------------------
// evs_checker: port-level checks for the signature verify block
// Watches start, busy and the result strobe over time.
// ----------------------------------------------------------------------------
`default_nettype none

module evs_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_valid,
   input wire logic pready
);

   // an accepted item makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block not busy after an item was accepted");

   // the result strobe closes an item: block is free in that cycle
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && $past(busy)))
      else $error("result strobe outside the end of an item");

   // one item gives one result: never two strobes in a row
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // configuration port never inserts wait states
   a_pready: assert property (@(posedge clock) disable iff (reset)
      pready)
      else $error("pready low");

endmodule

bind elgamal_signature_verify evs_checker u_evs_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .pready    (pready)
);

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the ElGamal signature verify block
// Loads key sets over the APB port and sends signature items: real signatures
// made here from random keys, corrupted copies and raw noise. Every item's
// verdict is predicted from y^s1 * s1^s2 == g^m (mod p) and checked in order.
// ----------------------------------------------------------------------------
module tb_top;

   localparam longint CYCLE_LIMIT = 25_000_000;
   localparam int DRAIN_CYCLES = 4000;
   localparam int OP_BITS = evs_pkg::MOD_BITS_DEF;
   localparam int ITEMS_PER_PHASE = 500;
   localparam int FW = evs_pkg::FIELD_W;
   localparam int RW = evs_pkg::REG_W;
   localparam int DW = evs_pkg::CSR_DATA_W;
   localparam int AW = evs_pkg::CSR_ADDR_W;
   localparam int IW = evs_pkg::REG_IDX_W;
   // address past the end of the register map
   localparam logic [IW-1:0] REG_UNUSED = 2'd3;

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   logic           psel = 1'b0;
   logic           penable = 1'b0;
   logic           pwrite = 1'b0;
   logic [AW-1:0]  paddr = '0;
   logic [DW-1:0]  pwdata = '0;
   logic [DW-1:0]  prdata;
   logic           pready;
   logic           start = 1'b0;
   logic           busy;
   logic [FW-1:0]  req_sig_first = '0;
   logic [FW-1:0]  req_sig_second = '0;
   logic [FW-1:0]  req_message = '0;
   logic           rsp_valid;
   logic           rsp_verified;

   // shadow copy of the configuration registers
   logic [RW-1:0] cfg_modulus = evs_pkg::MODULUS_RST;
   logic [RW-1:0] cfg_generator = evs_pkg::GENERATOR_RST;
   logic [RW-1:0] cfg_public_key = evs_pkg::PUBLIC_KEY_RST;

   // verdicts of accepted items, oldest first
   bit     expected_verdicts[$];
   int     fail_count = 0;
   int     items_sent = 0;
   int     verdicts_checked = 0;
   int     signed_items = 0;
   int     key_sets = 0;
   int     idle_pct = 0;
   longint cycle_count = 0;

   // current signing key: prime, generator, secret exponent
   longint key_prime;
   longint key_gen;
   longint key_secret;

   elgamal_signature_verify uut (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .start          (start),
      .busy           (busy),
      .req_sig_first  (req_sig_first),
      .req_sig_second (req_sig_second),
      .req_message    (req_message),
      .rsp_valid      (rsp_valid),
      .rsp_verified   (rsp_verified)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- math

   // base^expo mod m, right-to-left square-and-multiply
   function automatic longint unsigned pow_residue(input longint unsigned base,
                                                   input longint unsigned expo,
                                                   input longint unsigned m);
      longint unsigned acc;
      longint unsigned sq;
      longint unsigned e;
      acc = 1 % m;
      sq = base % m;
      e = expo;
      while (e != 0) begin
         if ((e & 1) != 0) acc = (acc * sq) % m;
         sq = (sq * sq) % m;
         e = e >> 1;
      end
      return acc;
   endfunction

   // verdict for one item under the current register values
   function automatic bit predicted_verdict(input logic [FW-1:0] s1,
                                            input logic [FW-1:0] s2,
                                            input logic [FW-1:0] msg);
      longint unsigned op_mask;
      longint unsigned p;
      longint unsigned g;
      longint unsigned y;
      longint unsigned lhs;
      longint unsigned rhs;
      op_mask = (64'd1 << OP_BITS) - 64'd1;
      p = 64'(cfg_modulus) & op_mask;
      g = 64'(cfg_generator) & op_mask;
      y = 64'(cfg_public_key) & op_mask;
      if (p < 2) return 1'b0;
      lhs = (pow_residue(y, 64'(s1), p) * pow_residue(64'(s1), 64'(s2), p)) % p;
      rhs = pow_residue(g, 64'(msg), p);
      return lhs == rhs;
   endfunction

   function automatic bit is_prime(input longint n);
      if (n < 2) return 1'b0;
      for (longint d = 2; d * d <= n; d++)
         if (n % d == 0) return 1'b0;
      return 1'b1;
   endfunction

   function automatic longint gcd(input longint a, input longint b);
      longint t;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   // inverse of a modulo n by extended Euclid; a and n coprime
   function automatic longint mod_inverse(input longint a, input longint n);
      longint t;
      longint nt;
      longint r;
      longint nr;
      longint q;
      longint tmp;
      t = 0;
      nt = 1;
      r = n;
      nr = a;
      while (nr != 0) begin
         q = r / nr;
         tmp = t - q * nt;
         t = nt;
         nt = tmp;
         tmp = r - q * nr;
         r = nr;
         nr = tmp;
      end
      if (t < 0) t += n;
      return t;
   endfunction

   // sign msg with the current key; fresh nonce coprime to p-1
   function automatic void sign_message(input longint msg, output longint r,
                                        output longint s);
      longint n;
      longint k;
      longint t;
      n = key_prime - 1;
      do k = longint'($urandom_range(32'(n - 1), 1)); while (gcd(k, n) != 1);
      r = pow_residue(key_gen, k, key_prime);
      t = (msg % n) - ((key_secret * r) % n);
      if (t < 0) t += n;
      s = (t * mod_inverse(k, n)) % n;
   endfunction

   // ------------------------------------------------------- monitor/checker

   // item accepted: start high while busy low
   always @(posedge clock) begin
      if (!reset && start && busy === 1'b0)
         expected_verdicts.push_back(predicted_verdict(req_sig_first, req_sig_second,
                                                       req_message));
   end

   // compare each strobed verdict with the oldest prediction
   always @(posedge clock) begin
      bit want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_verdicts.size() == 0) begin
            $error("verified: no item pending, actual %0d", rsp_verified);
            fail_count++;
         end else begin
            want = expected_verdicts.pop_front();
            verdicts_checked++;
            if (rsp_verified !== want) begin
               $error("verified: expected %0d, actual %0d", want, rsp_verified);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("elgamal_signature_verify: mismatch");
         $finish;
      end
   end

   // ---------------------------------------------------------------- drivers

   // drop start and wait until no item is in flight
   task automatic wait_idle();
      @(negedge clock);
      start <= 1'b0;
      while (expected_verdicts.size() != 0 || busy !== 1'b0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [IW-1:0] idx,
                            input logic [DW-1:0] value);
      wait_idle();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      case (idx)
         evs_pkg::REG_MODULUS:    cfg_modulus = value[RW-1:0];
         evs_pkg::REG_GENERATOR:  cfg_generator = value[RW-1:0];
         evs_pkg::REG_PUBLIC_KEY: cfg_public_key = value[RW-1:0];
         default: ;
      endcase
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic read_reg(input logic [IW-1:0] idx);
      logic [RW-1:0] want;
      string         name;
      case (idx)
         evs_pkg::REG_MODULUS:   begin want = cfg_modulus; name = "modulus"; end
         evs_pkg::REG_GENERATOR: begin want = cfg_generator; name = "generator"; end
         default:                begin want = cfg_public_key; name = "public_key"; end
      endcase
      wait_idle();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {idx, 2'b00};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (prdata[RW-1:0] !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, prdata[RW-1:0]);
         fail_count++;
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // present one item and hold it until accepted; optional gap after busy falls
   task automatic send_item(input logic [FW-1:0] s1, input logic [FW-1:0] s2,
                            input logic [FW-1:0] msg);
      int gap;
      gap = 0;
      if ($urandom_range(99, 0) < idle_pct) gap = $urandom_range(24, 1);
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         while (busy !== 1'b0) @(negedge clock);
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_sig_first <= s1;
      req_sig_second <= s2;
      req_message <= msg;
      do @(posedge clock); while (busy !== 1'b0);
      items_sent++;
   endtask

   task automatic send_signed(input longint msg);
      longint r;
      longint s;
      sign_message(msg, r, s);
      send_item(r[FW-1:0], s[FW-1:0], msg[FW-1:0]);
      signed_items++;
   endtask

   task automatic load_key_set();
      write_reg(evs_pkg::REG_MODULUS, DW'(key_prime));
      write_reg(evs_pkg::REG_GENERATOR, DW'(key_gen));
      write_reg(evs_pkg::REG_PUBLIC_KEY, DW'(pow_residue(key_gen, key_secret, key_prime)));
      key_sets++;
   endtask

   // random prime near [lo, hi], generator and secret, then load them
   task automatic pick_key_set(input int lo, input int hi);
      key_prime = longint'($urandom_range(hi, lo));
      while (!is_prime(key_prime)) key_prime++;
      key_gen = longint'($urandom_range(32'(key_prime - 1), 2));
      key_secret = longint'($urandom_range(32'(key_prime - 2), 1));
      load_key_set();
   endtask

   // ------------------------------------------------------------------ tests

   // reset values: p = 2, g = 1, y = 1
   task automatic test_reset_values();
      read_reg(evs_pkg::REG_MODULUS);
      read_reg(evs_pkg::REG_GENERATOR);
      read_reg(evs_pkg::REG_PUBLIC_KEY);
      send_item(16'd0, 16'd0, 16'd0);
      send_item(16'd6, 16'd3, 16'd9);
      send_item(16'hFFFF, 16'hFFFF, 16'hFFFF);
   endtask

   // modulus 0 and 1 always fail the check
   task automatic test_modulus_below_two();
      write_reg(evs_pkg::REG_MODULUS, 32'd0);
      send_item(16'd0, 16'd0, 16'd0);
      send_item(16'hFFFF, 16'd1, 16'd0);
      write_reg(evs_pkg::REG_MODULUS, 32'd1);
      send_item(16'd0, 16'd0, 16'd0);
   endtask

   // all-ones and zero operands, zero exponents, bases not below p
   task automatic test_operand_extremes();
      write_reg(evs_pkg::REG_MODULUS, 32'hFFFF);
      write_reg(evs_pkg::REG_GENERATOR, 32'hFFFF);
      write_reg(evs_pkg::REG_PUBLIC_KEY, 32'hFFFF);
      send_item(16'd0, 16'd0, 16'd0);
      send_item(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_item(16'd0, 16'hFFFF, 16'd0);
      send_item(16'hFFFF, 16'd0, 16'hFFFF);
      write_reg(evs_pkg::REG_GENERATOR, 32'd0);
      write_reg(evs_pkg::REG_PUBLIC_KEY, 32'd0);
      send_item(16'd0, 16'd0, 16'd0);
      send_item(16'd1, 16'd5, 16'd1);
      write_reg(evs_pkg::REG_MODULUS, 32'd7);
      write_reg(evs_pkg::REG_GENERATOR, 32'd3);
      write_reg(evs_pkg::REG_PUBLIC_KEY, 32'd5);
      send_item(16'd100, 16'd3, 16'd4);
   endtask

   // upper data bits dropped, write past the map ignored, read back
   task automatic test_register_map();
      key_prime = 17;
      key_gen = 3;
      key_secret = 5;
      write_reg(evs_pkg::REG_MODULUS, 32'hABCD_0011);
      write_reg(evs_pkg::REG_GENERATOR, 32'h5A5A_0003);
      write_reg(evs_pkg::REG_PUBLIC_KEY, DW'(pow_residue(key_gen, key_secret, key_prime)));
      write_reg(REG_UNUSED, 32'h0000_BEEF);
      read_reg(evs_pkg::REG_MODULUS);
      read_reg(evs_pkg::REG_GENERATOR);
      read_reg(evs_pkg::REG_PUBLIC_KEY);
      send_signed(9);
   endtask

   // genuine signatures, altered message, s1 lifted above p, largest prime
   task automatic test_known_signatures();
      longint r;
      longint s;
      key_prime = 467;
      key_gen = 2;
      key_secret = 127;
      load_key_set();
      sign_message(100, r, s);
      send_item(r[FW-1:0], s[FW-1:0], 16'd100);
      send_item(r[FW-1:0], s[FW-1:0], 16'd101);
      send_item(FW'(r + key_prime), s[FW-1:0], 16'd100);
      key_prime = 65521;
      key_gen = longint'($urandom_range(65520, 2));
      key_secret = longint'($urandom_range(65519, 1));
      load_key_set();
      send_signed(longint'($urandom_range(65535, 0)));
      send_signed(longint'($urandom_range(65535, 0)));
   endtask

   // mostly real signatures on small primes, some corrupted, some noise
   task automatic test_random_signatures(input int pct);
      int            first_item;
      int            choice;
      int            kind;
      longint        msg;
      longint        r;
      longint        s;
      logic [FW-1:0] f1;
      logic [FW-1:0] f2;
      logic [FW-1:0] f3;
      int            bitpos;
      idle_pct = pct;
      first_item = items_sent;
      while (items_sent - first_item < ITEMS_PER_PHASE) begin
         choice = $urandom_range(99, 0);
         if (choice < 5) begin
            // arbitrary register values, noise items
            case ($urandom_range(4, 0))
               0:       write_reg(evs_pkg::REG_MODULUS, 32'd0);
               1:       write_reg(evs_pkg::REG_MODULUS, 32'd1);
               2:       write_reg(evs_pkg::REG_MODULUS, 32'd2);
               3:       write_reg(evs_pkg::REG_MODULUS, 32'hFFFF);
               default: write_reg(evs_pkg::REG_MODULUS, $urandom_range(65535, 0));
            endcase
            write_reg(evs_pkg::REG_GENERATOR, $urandom_range(65535, 0));
            write_reg(evs_pkg::REG_PUBLIC_KEY, $urandom_range(65535, 0));
            repeat ($urandom_range(6, 3))
               send_item(FW'($urandom_range(65535, 0)), FW'($urandom_range(65535, 0)),
                         FW'($urandom_range(65535, 0)));
         end else begin
            if (choice < 80) pick_key_set(3, 251);
            else if (choice < 95) pick_key_set(256, 4093);
            else pick_key_set(30000, 65521);
            repeat ($urandom_range(16, 4)) begin
               kind = $urandom_range(99, 0);
               if ($urandom_range(3, 0) == 0) msg = longint'($urandom_range(65535, 0));
               else msg = longint'($urandom_range(32'(key_prime - 2), 0));
               if (kind < 75) begin
                  send_signed(msg);
               end else if (kind < 90) begin
                  // one bit flipped in one field of a real signature
                  sign_message(msg, r, s);
                  f1 = r[FW-1:0];
                  f2 = s[FW-1:0];
                  f3 = msg[FW-1:0];
                  bitpos = $urandom_range(FW - 1, 0);
                  case ($urandom_range(2, 0))
                     0:       f1[bitpos] = ~f1[bitpos];
                     1:       f2[bitpos] = ~f2[bitpos];
                     default: f3[bitpos] = ~f3[bitpos];
                  endcase
                  send_item(f1, f2, f3);
               end else begin
                  send_item(FW'($urandom_range(65535, 0)), FW'($urandom_range(65535, 0)),
                            FW'($urandom_range(65535, 0)));
               end
            end
         end
      end
   endtask

   // ------------------------------------------------------------------- main
   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_modulus_below_two();
      test_operand_extremes();
      test_register_map();
      test_known_signatures();
      test_random_signatures(18);
      test_random_signatures(53);
      test_random_signatures(0);

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_verdicts.size() != 0) begin
         $error("verified: %0d items never answered", expected_verdicts.size());
         fail_count++;
      end

      $display("Checked %0d verdicts for %0d items, %0d of them genuine signatures,",
               verdicts_checked, items_sent, signed_items);
      $display("under %0d key sets plus odd moduli from 0 up to 65535.", key_sets);
      if (fail_count == 0)
         $display("elgamal_signature_verify: match");
      else
         $display("elgamal_signature_verify: mismatch");
      $finish;
   end

endmodule
